/* design/assembly_token_lexer_core_macros.svh */
// Assertion macros shared by the lexer checker.
// Depends on a clock named clk and a reset named rst in the including scope.
`ifndef ASSEMBLY_TOKEN_LEXER_CORE_MACROS_SVH
`define ASSEMBLY_TOKEN_LEXER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ATL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ATL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define ATL_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/atl_pkg.sv */
// Types, codes, character constants and the register name table of the lexer.
// No dependencies.
package atl_pkg;

  localparam int NUMBER_WIDTH = 32;
  localparam int VALUE_W      = 33;
  localparam int NUM_REGS     = 64;

  typedef logic [NUMBER_WIDTH-1:0] num_t;

  typedef enum logic [3:0] {
    K_IDENT_CHAR = 4'd0,
    K_IDENT_END  = 4'd1,
    K_REG        = 4'd2,
    K_RIP        = 4'd3,
    K_NUM        = 4'd4,
    K_IMM        = 4'd5,
    K_STR_CHAR   = 4'd6,
    K_STR_END    = 4'd7,
    K_COMMA      = 4'd8,
    K_LPAREN     = 4'd9,
    K_RPAREN     = 4'd10,
    K_COLON      = 4'd11,
    K_EOL        = 4'd12,
    K_ERROR      = 4'd13
  } kind_t;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_UNKNOWN_REG = 3'd1;
  localparam logic [2:0] ERR_BAD_IMM    = 3'd2;
  localparam logic [2:0] ERR_BAD_ESCAPE = 3'd3;
  localparam logic [2:0] ERR_BAD_CHAR   = 3'd4;

  localparam logic [7:0] CH_EOL       = 8'h00;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_DOLLAR    = 8'h24;
  localparam logic [7:0] CH_PERCENT   = 8'h25;
  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_UPPER_A   = 8'h41;
  localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDERLINE = 8'h5F;
  localparam logic [7:0] CH_LOWER_A   = 8'h61;
  localparam logic [7:0] CH_LOWER_N   = 8'h6E;
  localparam logic [7:0] CH_LOWER_Z   = 8'h7A;

  // Names are right-justified, first character highest, zero-padded.
  localparam logic [31:0] RIP_NAME = "rip";

  localparam logic [31:0] REG_NAMES [NUM_REGS] = '{
    "al",   "ax",   "eax",  "rax",  "cl",   "cx",   "ecx",  "rcx",
    "dl",   "dx",   "edx",  "rdx",  "bl",   "bx",   "ebx",  "rbx",
    "spl",  "sp",   "esp",  "rsp",  "bpl",  "bp",   "ebp",  "rbp",
    "sil",  "si",   "esi",  "rsi",  "dil",  "di",   "edi",  "rdi",
    "r8b",  "r8w",  "r8d",  "r8",   "r9b",  "r9w",  "r9d",  "r9",
    "r10b", "r10w", "r10d", "r10",  "r11b", "r11w", "r11d", "r11",
    "r12b", "r12w", "r12d", "r12",  "r13b", "r13w", "r13d", "r13",
    "r14b", "r14w", "r14d", "r14",  "r15b", "r15w", "r15d", "r15"
  };

  typedef struct packed {
    kind_t              kind;
    logic signed [32:0] value;
    logic [1:0]         reg_size;
    logic [3:0]         reg_code;
    logic [2:0]         error_code;
  } result_t;

  typedef struct packed {
    logic       found;
    logic [5:0] idx;
  } lookup_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
           ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z));
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || is_alpha(c);
  endfunction

  function automatic logic is_ident_start(input logic [7:0] c);
    return (c == CH_DOT) || (c == CH_UNDERLINE) || is_alpha(c);
  endfunction

  function automatic result_t make_result(input kind_t k, input logic [32:0] v,
                                          input logic [1:0] sz, input logic [3:0] code,
                                          input logic [2:0] err);
    result_t r;
    r.kind       = k;
    r.value      = v;
    r.reg_size   = sz;
    r.reg_code   = code;
    r.error_code = err;
    return r;
  endfunction

  // Names of one to four characters are compared against all table entries at once.
  function automatic lookup_t reg_lookup(input logic [31:0] name, input logic [2:0] len);
    lookup_t r;
    r.found = 1'b0;
    r.idx   = '0;
    if ((len != 3'd0) && (len <= 3'd4)) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        if (name == REG_NAMES[i]) begin
          r.found = 1'b1;
          r.idx   = 6'(i);
        end
      end
    end
    return r;
  endfunction

endpackage

/* design/atl_char_if.sv */
// Source byte channel of the lexer: valid, ready and one character byte.
// No dependencies.
interface atl_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source(output valid, output char_code, input ready);
  modport sink(input valid, input char_code, output ready);
endinterface

/* design/atl_tok_if.sv */
// Token result channel of the lexer: valid, ready and the result fields.
// No dependencies.
interface atl_tok_if;
  logic               valid;
  logic               ready;
  logic [3:0]         kind;
  logic signed [32:0] value;
  logic [1:0]         reg_size;
  logic [3:0]         reg_code;
  logic [2:0]         error_code;

  modport source(output valid, output kind, output value, output reg_size,
                 output reg_code, output error_code, input ready);
  modport sink(input valid, input kind, input value, input reg_size,
               input reg_code, input error_code, output ready);
endinterface

/* design/assembly_token_lexer_core.sv */
// Streaming lexer for x86-64 assembly text in Unix assembler syntax; uses atl_pkg and interfaces.
// Each accepted byte is lexed in the cycle it is accepted; its zero to two results
// enter a four-entry result queue, which registers them before they reach the output.
// One byte per cycle is taken while the queue has room for two results; the single result
// port drains one per cycle while the sink is ready; this bounds bytes that yield two results.
// Synchronous reset returns the lexer to idle and empties the result queue.
module assembly_token_lexer_core (
  input  logic      clk,
  input  logic      rst,
  atl_char_if.sink  chars,
  atl_tok_if.source tokens
);

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_REG, M_NUM, M_IMMSTART, M_IMM, M_STR, M_ESC, M_SKIP
  } mode_t;

  mode_t         mode, mode_next;
  atl_pkg::num_t acc, acc_next;
  logic          negative, negative_next;
  logic [31:0]   reg_name, reg_name_next;
  logic [2:0]    reg_len, reg_len_next;

  atl_pkg::result_t queue [4];
  logic [1:0]       wr_ptr, rd_ptr;
  logic [2:0]       count;

  logic [7:0]       c;
  atl_pkg::num_t    acc_step, num_val;
  atl_pkg::lookup_t lookup;
  logic             do_idle, flt;
  logic [2:0]       flt_code;
  logic             p1v, p2v;
  atl_pkg::result_t p1, p2, r0, r1;
  logic [1:0]       cnt;
  logic             push, pop;
  logic [1:0]       push_n;

  always_comb begin
    c        = chars.char_code;
    acc_step = atl_pkg::num_t'((acc << 3) + (acc << 1)) +
               atl_pkg::num_t'(c - atl_pkg::CH_ZERO);
    num_val  = negative ? atl_pkg::num_t'(-acc) : acc;
    lookup   = atl_pkg::reg_lookup(reg_name, reg_len);

    mode_next     = mode;
    acc_next      = acc;
    negative_next = negative;
    reg_name_next = reg_name;
    reg_len_next  = reg_len;
    do_idle       = 1'b0;
    flt           = 1'b0;
    flt_code      = atl_pkg::ERR_NONE;
    p1v           = 1'b0;
    p1            = '0;
    p2v           = 1'b0;
    p2            = '0;

    case (mode)
      M_IDENT: begin
        if (atl_pkg::is_ident_start(c) || atl_pkg::is_digit(c)) begin
          p1v = 1'b1;
          p1  = atl_pkg::make_result(atl_pkg::K_IDENT_CHAR, 33'(c), '0, '0, '0);
        end else begin
          p1v     = 1'b1;
          p1      = atl_pkg::make_result(atl_pkg::K_IDENT_END, '0, '0, '0, '0);
          do_idle = 1'b1;
        end
      end
      M_REG: begin
        if (atl_pkg::is_alnum(c)) begin
          if (reg_len < 3'd4) reg_name_next = {reg_name[23:0], c};
          if (reg_len < 3'd5) reg_len_next = reg_len + 3'd1;
        end else if ((reg_len == 3'd3) && (reg_name == atl_pkg::RIP_NAME)) begin
          p1v     = 1'b1;
          p1      = atl_pkg::make_result(atl_pkg::K_RIP, '0, '0, '0, '0);
          do_idle = 1'b1;
        end else if (lookup.found) begin
          p1v     = 1'b1;
          p1      = atl_pkg::make_result(atl_pkg::K_REG, '0, lookup.idx[1:0],
                                         lookup.idx[5:2], '0);
          do_idle = 1'b1;
        end else begin
          flt      = 1'b1;
          flt_code = atl_pkg::ERR_UNKNOWN_REG;
        end
      end
      M_NUM: begin
        if (atl_pkg::is_digit(c)) begin
          acc_next = acc_step;
        end else begin
          p1v     = 1'b1;
          p1      = atl_pkg::make_result(atl_pkg::K_NUM,
                                         atl_pkg::VALUE_W'($signed(num_val)), '0, '0, '0);
          do_idle = 1'b1;
        end
      end
      M_IMMSTART: begin
        if (atl_pkg::is_digit(c)) begin
          acc_next  = acc_step;
          mode_next = M_IMM;
        end else begin
          flt      = 1'b1;
          flt_code = atl_pkg::ERR_BAD_IMM;
        end
      end
      M_IMM: begin
        if (atl_pkg::is_digit(c)) begin
          acc_next = acc_step;
        end else begin
          p1v     = 1'b1;
          p1      = atl_pkg::make_result(atl_pkg::K_IMM, atl_pkg::VALUE_W'(acc),
                                         '0, '0, '0);
          do_idle = 1'b1;
        end
      end
      M_STR: begin
        if (c == atl_pkg::CH_QUOTE) begin
          mode_next = M_IDLE;
          p1v       = 1'b1;
          p1        = atl_pkg::make_result(atl_pkg::K_STR_END, '0, '0, '0, '0);
        end else if (c == atl_pkg::CH_BACKSLASH) begin
          mode_next = M_ESC;
        end else if (c == atl_pkg::CH_EOL) begin
          flt      = 1'b1;
          flt_code = atl_pkg::ERR_BAD_CHAR;
        end else begin
          p1v = 1'b1;
          p1  = atl_pkg::make_result(atl_pkg::K_STR_CHAR, 33'(c), '0, '0, '0);
        end
      end
      M_ESC: begin
        mode_next = M_STR;
        if ((c == atl_pkg::CH_QUOTE) || (c == atl_pkg::CH_BACKSLASH)) begin
          p1v = 1'b1;
          p1  = atl_pkg::make_result(atl_pkg::K_STR_CHAR, 33'(c), '0, '0, '0);
        end else if (c == atl_pkg::CH_LOWER_N) begin
          p1v = 1'b1;
          p1  = atl_pkg::make_result(atl_pkg::K_STR_CHAR, 33'(atl_pkg::CH_NEWLINE),
                                     '0, '0, '0);
        end else if (c == atl_pkg::CH_ZERO) begin
          p1v = 1'b1;
          p1  = atl_pkg::make_result(atl_pkg::K_STR_CHAR, '0, '0, '0, '0);
        end else begin
          flt      = 1'b1;
          flt_code = atl_pkg::ERR_BAD_ESCAPE;
        end
      end
      M_SKIP: begin
        if (c == atl_pkg::CH_EOL) begin
          mode_next = M_IDLE;
          p1v       = 1'b1;
          p1        = atl_pkg::make_result(atl_pkg::K_EOL, '0, '0, '0, '0);
        end
      end
      default: begin
        do_idle = 1'b1;
      end
    endcase

    // A fault on the end-of-line byte closes the line in the same step.
    if (flt) begin
      p1v = 1'b1;
      p1  = atl_pkg::make_result(atl_pkg::K_ERROR, '0, '0, '0, flt_code);
      if (c == atl_pkg::CH_EOL) begin
        p2v       = 1'b1;
        p2        = atl_pkg::make_result(atl_pkg::K_EOL, '0, '0, '0, '0);
        mode_next = M_IDLE;
      end else begin
        mode_next = M_SKIP;
      end
    end

    // The byte that ends an identifier, register, number or immediate, or any byte between tokens, may start a new one.
    if (do_idle) begin
      mode_next = M_IDLE;
      if ((c == atl_pkg::CH_SPACE) || (c == atl_pkg::CH_TAB)) begin
        mode_next = M_IDLE;
      end else if (c == atl_pkg::CH_EOL) begin
        p2v = 1'b1;
        p2  = atl_pkg::make_result(atl_pkg::K_EOL, '0, '0, '0, '0);
      end else if (atl_pkg::is_ident_start(c)) begin
        mode_next = M_IDENT;
        p2v       = 1'b1;
        p2        = atl_pkg::make_result(atl_pkg::K_IDENT_CHAR, 33'(c), '0, '0, '0);
      end else if (c == atl_pkg::CH_PERCENT) begin
        mode_next     = M_REG;
        reg_len_next  = '0;
        reg_name_next = '0;
      end else if ((c == atl_pkg::CH_PLUS) || (c == atl_pkg::CH_MINUS) ||
                   atl_pkg::is_digit(c)) begin
        mode_next     = M_NUM;
        negative_next = (c == atl_pkg::CH_MINUS);
        acc_next      = atl_pkg::is_digit(c) ?
                        atl_pkg::num_t'(c - atl_pkg::CH_ZERO) : '0;
      end else if (c == atl_pkg::CH_DOLLAR) begin
        mode_next = M_IMMSTART;
        acc_next  = '0;
      end else if (c == atl_pkg::CH_QUOTE) begin
        mode_next = M_STR;
      end else if (c == atl_pkg::CH_COMMA) begin
        p2v = 1'b1;
        p2  = atl_pkg::make_result(atl_pkg::K_COMMA, '0, '0, '0, '0);
      end else if (c == atl_pkg::CH_LPAREN) begin
        p2v = 1'b1;
        p2  = atl_pkg::make_result(atl_pkg::K_LPAREN, '0, '0, '0, '0);
      end else if (c == atl_pkg::CH_RPAREN) begin
        p2v = 1'b1;
        p2  = atl_pkg::make_result(atl_pkg::K_RPAREN, '0, '0, '0, '0);
      end else if (c == atl_pkg::CH_COLON) begin
        p2v = 1'b1;
        p2  = atl_pkg::make_result(atl_pkg::K_COLON, '0, '0, '0, '0);
      end else begin
        mode_next = M_SKIP;
        p2v       = 1'b1;
        p2        = atl_pkg::make_result(atl_pkg::K_ERROR, '0, '0, '0,
                                         atl_pkg::ERR_BAD_CHAR);
      end
    end

    if (p1v) begin
      r0  = p1;
      r1  = p2;
      cnt = p2v ? 2'd2 : 2'd1;
    end else begin
      r0  = p2;
      r1  = '0;
      cnt = p2v ? 2'd1 : 2'd0;
    end
  end

  assign chars.ready = (count <= 3'd2);
  assign push        = chars.valid && chars.ready;
  assign pop         = tokens.valid && tokens.ready;
  assign push_n      = push ? cnt : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= M_IDLE;
      acc      <= '0;
      negative <= 1'b0;
      reg_name <= '0;
      reg_len  <= '0;
    end else if (push) begin
      mode     <= mode_next;
      acc      <= acc_next;
      negative <= negative_next;
      reg_name <= reg_name_next;
      reg_len  <= reg_len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count + {1'b0, push_n} - {2'b0, pop};
    end
    if (push_n != 2'd0) queue[wr_ptr] <= r0;
    if (push_n == 2'd2) queue[wr_ptr + 2'd1] <= r1;
  end

  assign tokens.valid      = (count != 3'd0);
  assign tokens.kind       = queue[rd_ptr].kind;
  assign tokens.value      = queue[rd_ptr].value;
  assign tokens.reg_size   = queue[rd_ptr].reg_size;
  assign tokens.reg_code   = queue[rd_ptr].reg_code;
  assign tokens.error_code = queue[rd_ptr].error_code;

endmodule

/* design/atl_checker.sv */
// Port-level checks of the lexer and the bind that attaches them to the top level.
// Depends on atl_pkg and assembly_token_lexer_core_macros.svh.
`include "assembly_token_lexer_core_macros.svh"

module atl_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [3:0]         kind,
  input logic signed [32:0] value,
  input logic [1:0]         reg_size,
  input logic [3:0]         reg_code,
  input logic [2:0]         error_code
);

  logic        stall;
  logic [45:0] payload;
  logic        is_reg;
  logic        reg_zero;
  logic        is_err;
  logic        err_set;

  assign stall    = out_valid && !out_ready;
  assign payload  = {kind, value, reg_size, reg_code, error_code};
  assign is_reg   = (kind == atl_pkg::K_REG);
  assign reg_zero = (reg_size == 2'd0) && (reg_code == 4'd0);
  assign is_err   = (kind == atl_pkg::K_ERROR);
  assign err_set  = (error_code != atl_pkg::ERR_NONE);

  `ATL_ASSERT_NEXT(a_stall_holds, stall, out_valid && $stable(payload), "stalled item changed")
  `ATL_ASSERT_NOW(a_reg_fields, out_valid && !is_reg, reg_zero, "stray register fields")
  `ATL_ASSERT_NOW(a_error_code, out_valid, is_err == err_set, "error code does not match kind")
  `ATL_ASSERT_NEXT_ALWAYS(a_reset_empty, rst, !out_valid, "result shown right after reset")

endmodule

bind assembly_token_lexer_core atl_checker u_atl_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (tokens.valid),
  .out_ready  (tokens.ready),
  .kind       (tokens.kind),
  .value      (tokens.value),
  .reg_size   (tokens.reg_size),
  .reg_code   (tokens.reg_code),
  .error_code (tokens.error_code)
);

/* bench/assembly_token_lexer_core_tb.sv */
// Self-checking testbench for assembly_token_lexer_core: random and directed assembly lines in,
// tokens checked against a predictor of the lexer. Uses atl_pkg, atl_char_if and atl_tok_if.
// Both handshakes idle and stall at random; one phase fills the result queue on purpose.
module assembly_token_lexer_core_tb;

  localparam int CYCLE_LIMIT = 500000;

  typedef enum {
    SCAN_IDLE, SCAN_IDENT, SCAN_REG, SCAN_NUM, SCAN_IMM_START, SCAN_IMM,
    SCAN_STR, SCAN_ESC, SCAN_SKIP_LINE
  } scan_mode_t;

  logic clk;
  logic rst;

  atl_char_if chars_bus();
  atl_tok_if  tok_bus();

  assembly_token_lexer_core uut (
    .clk(clk),
    .rst(rst),
    .chars(chars_bus),
    .tokens(tok_bus)
  );

  string gpr_names [64] = '{
    "al",   "ax",   "eax",  "rax",  "cl",   "cx",   "ecx",  "rcx",
    "dl",   "dx",   "edx",  "rdx",  "bl",   "bx",   "ebx",  "rbx",
    "spl",  "sp",   "esp",  "rsp",  "bpl",  "bp",   "ebp",  "rbp",
    "sil",  "si",   "esi",  "rsi",  "dil",  "di",   "edi",  "rdi",
    "r8b",  "r8w",  "r8d",  "r8",   "r9b",  "r9w",  "r9d",  "r9",
    "r10b", "r10w", "r10d", "r10",  "r11b", "r11w", "r11d", "r11",
    "r12b", "r12w", "r12d", "r12",  "r13b", "r13w", "r13d", "r13",
    "r14b", "r14w", "r14d", "r14",  "r15b", "r15w", "r15d", "r15"
  };

  string big_numbers [5] = '{"4294967295", "4294967296", "2147483648", "0", "99999999999"};

  scan_mode_t    scan_mode;
  atl_pkg::num_t num_acc;
  bit            num_neg;
  logic [7:0]    reg_chars [4];
  int            reg_len;

  atl_pkg::result_t token_queue [$];
  logic [7:0]       line_buf [$];

  int mismatch_count;
  int bytes_sent;
  int cycle_count;
  int sink_gap;
  int sink_hold;
  bit src_idle;
  bit sink_idle;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bit is_dec(logic [7:0] c);
    return (c >= atl_pkg::CH_ZERO) && (c <= atl_pkg::CH_NINE);
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return ((c >= atl_pkg::CH_LOWER_A) && (c <= atl_pkg::CH_LOWER_Z)) ||
           ((c >= atl_pkg::CH_UPPER_A) && (c <= atl_pkg::CH_UPPER_Z));
  endfunction

  function automatic void queue_token(atl_pkg::kind_t k,
                                      logic [atl_pkg::VALUE_W-1:0] v = '0,
                                      logic [1:0] sz = '0, logic [3:0] code = '0,
                                      logic [2:0] err = atl_pkg::ERR_NONE);
    atl_pkg::result_t r;
    r.kind       = k;
    r.value      = v;
    r.reg_size   = sz;
    r.reg_code   = code;
    r.error_code = err;
    token_queue.push_back(r);
  endfunction

  function automatic void flag_fault(logic [2:0] err, logic [7:0] c);
    queue_token(atl_pkg::K_ERROR, '0, '0, '0, err);
    if (c == atl_pkg::CH_EOL) begin
      queue_token(atl_pkg::K_EOL);
      scan_mode = SCAN_IDLE;
    end else begin
      scan_mode = SCAN_SKIP_LINE;
    end
  endfunction

  function automatic void add_digit(logic [7:0] c);
    num_acc = num_acc * 10 + atl_pkg::num_t'(c - atl_pkg::CH_ZERO);
  endfunction

  function automatic void begin_token(logic [7:0] c);
    scan_mode = SCAN_IDLE;
    if (c == atl_pkg::CH_SPACE || c == atl_pkg::CH_TAB) begin
    end else if (c == atl_pkg::CH_EOL) begin
      queue_token(atl_pkg::K_EOL);
    end else if (c == atl_pkg::CH_DOT || c == atl_pkg::CH_UNDERLINE || is_letter(c)) begin
      scan_mode = SCAN_IDENT;
      queue_token(atl_pkg::K_IDENT_CHAR, atl_pkg::VALUE_W'(c));
    end else if (c == atl_pkg::CH_PERCENT) begin
      scan_mode = SCAN_REG;
      reg_len = 0;
      for (int k = 0; k < 4; k++) reg_chars[k] = 8'h00;
    end else if (c == atl_pkg::CH_PLUS || c == atl_pkg::CH_MINUS || is_dec(c)) begin
      scan_mode = SCAN_NUM;
      num_neg = (c == atl_pkg::CH_MINUS);
      num_acc = is_dec(c) ? atl_pkg::num_t'(c - atl_pkg::CH_ZERO) : '0;
    end else if (c == atl_pkg::CH_DOLLAR) begin
      scan_mode = SCAN_IMM_START;
      num_acc = '0;
    end else if (c == atl_pkg::CH_QUOTE) begin
      scan_mode = SCAN_STR;
    end else if (c == atl_pkg::CH_COMMA) begin
      queue_token(atl_pkg::K_COMMA);
    end else if (c == atl_pkg::CH_LPAREN) begin
      queue_token(atl_pkg::K_LPAREN);
    end else if (c == atl_pkg::CH_RPAREN) begin
      queue_token(atl_pkg::K_RPAREN);
    end else if (c == atl_pkg::CH_COLON) begin
      queue_token(atl_pkg::K_COLON);
    end else begin
      flag_fault(atl_pkg::ERR_BAD_CHAR, c);
    end
  endfunction

  function automatic int reg_index();
    string name = "";
    if (reg_len == 0 || reg_len > 4) return -1;
    for (int k = 0; k < reg_len; k++) name = $sformatf("%s%c", name, reg_chars[k]);
    for (int i = 0; i < 64; i++) begin
      if (name == gpr_names[i]) return i;
    end
    return -1;
  endfunction

  function automatic void lex_byte(logic [7:0] c);
    int idx;
    atl_pkg::num_t v;
    logic signed [atl_pkg::VALUE_W-1:0] nv;
    case (scan_mode)
      SCAN_IDENT: begin
        if (c == atl_pkg::CH_DOT || c == atl_pkg::CH_UNDERLINE || is_letter(c) || is_dec(c))
        begin
          queue_token(atl_pkg::K_IDENT_CHAR, atl_pkg::VALUE_W'(c));
        end else begin
          queue_token(atl_pkg::K_IDENT_END);
          begin_token(c);
        end
      end
      SCAN_REG: begin
        if (is_letter(c) || is_dec(c)) begin
          if (reg_len < 4) reg_chars[reg_len] = c;
          if (reg_len < 5) reg_len++;
        end else if (reg_len == 3 && reg_chars[0] == "r" && reg_chars[1] == "i" &&
                     reg_chars[2] == "p") begin
          queue_token(atl_pkg::K_RIP);
          begin_token(c);
        end else begin
          idx = reg_index();
          if (idx < 0) begin
            flag_fault(atl_pkg::ERR_UNKNOWN_REG, c);
          end else begin
            queue_token(atl_pkg::K_REG, '0, idx[1:0], idx[5:2]);
            begin_token(c);
          end
        end
      end
      SCAN_NUM: begin
        if (is_dec(c)) begin
          add_digit(c);
        end else begin
          v = num_neg ? atl_pkg::num_t'(-num_acc) : num_acc;
          nv = atl_pkg::VALUE_W'($signed(v));
          queue_token(atl_pkg::K_NUM, nv);
          begin_token(c);
        end
      end
      SCAN_IMM_START: begin
        if (!is_dec(c)) begin
          flag_fault(atl_pkg::ERR_BAD_IMM, c);
        end else begin
          add_digit(c);
          scan_mode = SCAN_IMM;
        end
      end
      SCAN_IMM: begin
        if (is_dec(c)) begin
          add_digit(c);
        end else begin
          queue_token(atl_pkg::K_IMM, atl_pkg::VALUE_W'(num_acc));
          begin_token(c);
        end
      end
      SCAN_STR: begin
        if (c == atl_pkg::CH_QUOTE) begin
          scan_mode = SCAN_IDLE;
          queue_token(atl_pkg::K_STR_END);
        end else if (c == atl_pkg::CH_BACKSLASH) begin
          scan_mode = SCAN_ESC;
        end else if (c == atl_pkg::CH_EOL) begin
          flag_fault(atl_pkg::ERR_BAD_CHAR, c);
        end else begin
          queue_token(atl_pkg::K_STR_CHAR, atl_pkg::VALUE_W'(c));
        end
      end
      SCAN_ESC: begin
        scan_mode = SCAN_STR;
        if (c == atl_pkg::CH_QUOTE || c == atl_pkg::CH_BACKSLASH)
          queue_token(atl_pkg::K_STR_CHAR, atl_pkg::VALUE_W'(c));
        else if (c == atl_pkg::CH_LOWER_N)
          queue_token(atl_pkg::K_STR_CHAR, atl_pkg::VALUE_W'(atl_pkg::CH_NEWLINE));
        else if (c == atl_pkg::CH_ZERO)
          queue_token(atl_pkg::K_STR_CHAR, '0);
        else
          flag_fault(atl_pkg::ERR_BAD_ESCAPE, c);
      end
      SCAN_SKIP_LINE: begin
        if (c == atl_pkg::CH_EOL) begin
          scan_mode = SCAN_IDLE;
          queue_token(atl_pkg::K_EOL);
        end
      end
      default: begin_token(c);
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  always @(posedge clk) begin
    if (!rst && chars_bus.valid && chars_bus.ready) lex_byte(chars_bus.char_code);
  end

  always @(posedge clk) begin
    atl_pkg::result_t want;
    if (!rst && tok_bus.valid && tok_bus.ready) begin
      if (token_queue.size() == 0) begin
        report_mismatch($sformatf("token kind %0d with nothing expected", tok_bus.kind));
      end else begin
        want = token_queue.pop_front();
        if (tok_bus.kind !== want.kind)
          report_mismatch($sformatf("kind %0d, expected %0d (%s)", tok_bus.kind, want.kind,
                                    want.kind.name()));
        if (tok_bus.value !== want.value)
          report_mismatch($sformatf("%s value %0d, expected %0d", want.kind.name(),
                                    tok_bus.value, want.value));
        if (tok_bus.reg_size !== want.reg_size)
          report_mismatch($sformatf("%s reg_size %0d, expected %0d", want.kind.name(),
                                    tok_bus.reg_size, want.reg_size));
        if (tok_bus.reg_code !== want.reg_code)
          report_mismatch($sformatf("%s reg_code %0d, expected %0d", want.kind.name(),
                                    tok_bus.reg_code, want.reg_code));
        if (tok_bus.error_code !== want.error_code)
          report_mismatch($sformatf("%s error_code %0d, expected %0d", want.kind.name(),
                                    tok_bus.error_code, want.error_code));
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      tok_bus.ready <= 1'b0;
    end else begin
      if (tok_bus.valid && tok_bus.ready) sink_gap = sink_idle ? $urandom_range(0, 7) : 0;
      if (sink_hold > 0) begin
        sink_hold--;
        tok_bus.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        tok_bus.ready <= 1'b0;
      end else begin
        tok_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  function automatic void put_byte(logic [7:0] c);
    line_buf.push_back(c);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function automatic void put_blanks();
    repeat ($urandom_range(1, 2))
      put_byte($urandom_range(0, 1) ? atl_pkg::CH_SPACE : atl_pkg::CH_TAB);
  endfunction

  function automatic logic [7:0] rand_alnum();
    case ($urandom_range(0, 2))
      0: return 8'(atl_pkg::CH_ZERO + $urandom_range(0, 9));
      1: return 8'(atl_pkg::CH_UPPER_A + $urandom_range(0, 25));
      default: return 8'(atl_pkg::CH_LOWER_A + $urandom_range(0, 25));
    endcase
  endfunction

  function automatic void put_digits();
    if ($urandom_range(0, 7) == 0) put_text(big_numbers[$urandom_range(0, 4)]);
    else repeat ($urandom_range(1, 11)) put_byte(8'(atl_pkg::CH_ZERO + $urandom_range(0, 9)));
  endfunction

  function automatic void put_ident();
    case ($urandom_range(0, 9))
      0: put_byte(atl_pkg::CH_DOT);
      1: put_byte(atl_pkg::CH_UNDERLINE);
      2, 3: put_byte(8'(atl_pkg::CH_UPPER_A + $urandom_range(0, 25)));
      default: put_byte(8'(atl_pkg::CH_LOWER_A + $urandom_range(0, 25)));
    endcase
    repeat ($urandom_range(0, 6)) begin
      if ($urandom_range(0, 7) == 0)
        put_byte($urandom_range(0, 1) ? atl_pkg::CH_DOT : atl_pkg::CH_UNDERLINE);
      else put_byte(rand_alnum());
    end
  endfunction

  function automatic void put_register();
    int r;
    r = $urandom_range(0, 19);
    put_byte(atl_pkg::CH_PERCENT);
    if (r < 16) put_text(gpr_names[$urandom_range(0, 63)]);
    else if (r < 18) put_text("rip");
    else repeat ($urandom_range(0, 6)) put_byte(rand_alnum());
  endfunction

  function automatic void put_operand();
    int sign;
    logic [7:0] c;
    case ($urandom_range(0, 7))
      0, 1: put_register();
      2: begin
        put_byte(atl_pkg::CH_DOLLAR);
        if ($urandom_range(0, 11) != 0) put_digits();
      end
      3: begin
        sign = $urandom_range(0, 2);
        if (sign == 1) put_byte(atl_pkg::CH_MINUS);
        if (sign == 2) put_byte(atl_pkg::CH_PLUS);
        if (sign == 0 || $urandom_range(0, 3) != 0) put_digits();
      end
      4, 5: begin
        if ($urandom_range(0, 1) == 0) begin
          if ($urandom_range(0, 1) == 0) put_byte(atl_pkg::CH_MINUS);
          put_digits();
        end
        put_byte(atl_pkg::CH_LPAREN);
        if ($urandom_range(0, 7) != 0) put_register();
        if ($urandom_range(0, 1) == 0) begin
          put_byte(atl_pkg::CH_COMMA);
          put_register();
          if ($urandom_range(0, 1) == 0) begin
            put_byte(atl_pkg::CH_COMMA);
            put_byte(8'(atl_pkg::CH_ZERO + $urandom_range(0, 9)));
          end
        end
        put_byte(atl_pkg::CH_RPAREN);
      end
      6: begin
        put_byte(atl_pkg::CH_QUOTE);
        repeat ($urandom_range(0, 8)) begin
          if ($urandom_range(0, 4) == 0) begin
            put_byte(atl_pkg::CH_BACKSLASH);
            case ($urandom_range(0, 8))
              0, 1: put_byte(atl_pkg::CH_QUOTE);
              2, 3: put_byte(atl_pkg::CH_BACKSLASH);
              4, 5: put_byte(atl_pkg::CH_LOWER_N);
              6, 7: put_byte(atl_pkg::CH_ZERO);
              default: put_byte(8'($urandom_range(0, 255)));
            endcase
          end else begin
            c = 8'($urandom_range(1, 255));
            if (c == atl_pkg::CH_QUOTE || c == atl_pkg::CH_BACKSLASH) c = atl_pkg::CH_LOWER_A;
            put_byte(c);
          end
        end
        if ($urandom_range(0, 9) != 0) put_byte(atl_pkg::CH_QUOTE);
      end
      default: put_ident();
    endcase
  endfunction

  function automatic void build_line();
    int n_ops;
    if ($urandom_range(0, 4) == 0) begin
      put_ident();
      put_byte(atl_pkg::CH_COLON);
      put_blanks();
    end
    put_ident();
    n_ops = $urandom_range(0, 3);
    for (int i = 0; i < n_ops; i++) begin
      if (i == 0) begin
        put_blanks();
      end else begin
        put_byte(atl_pkg::CH_COMMA);
        if ($urandom_range(0, 2) == 0) put_blanks();
      end
      put_operand();
    end
    if ($urandom_range(0, 3) == 0) put_blanks();
    put_byte(atl_pkg::CH_EOL);
  endfunction

  task automatic send_byte(input logic [7:0] c);
    int gap;
    gap = src_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      chars_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    chars_bus.valid <= 1'b1;
    chars_bus.char_code <= c;
    do @(posedge clk); while (!chars_bus.ready);
    bytes_sent++;
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_byte(line_buf[i]);
    line_buf.delete();
  endtask

  task automatic wait_drained();
    chars_bus.valid <= 1'b0;
    do @(posedge clk); while (token_queue.size() != 0);
  endtask

  task automatic test_directed_lines();
    src_idle = 1'b1;
    sink_idle = 1'b1;
    put_text("_a.9:%r15b,-9)");
    put_byte(atl_pkg::CH_EOL);
    put_text("%al\t+,$4294967296(%rip");
    put_byte(atl_pkg::CH_EOL);
    put_text("\"\\n\\0\\q");
    put_byte(atl_pkg::CH_EOL);
    put_text("%rip($");
    put_byte(atl_pkg::CH_EOL);
    put_text("+ $0\"\\\"\\\\");
    put_byte(atl_pkg::CH_EOL);
    put_text("%abcde");
    put_byte(atl_pkg::CH_EOL);
    put_byte(8'hFF);
    put_byte(atl_pkg::CH_LOWER_A);
    put_byte(atl_pkg::CH_EOL);
    send_line();
    wait_drained();
  endtask

  task automatic test_random_lines(input int target);
    int mix;
    while (bytes_sent < target) begin
      src_idle = $urandom_range(0, 3) != 0;
      sink_idle = $urandom_range(0, 3) != 0;
      mix = $urandom_range(0, 23);
      if (mix < 2) begin
        repeat ($urandom_range(1, 12)) put_byte(8'($urandom_range(0, 255)));
        put_byte(atl_pkg::CH_EOL);
      end else begin
        build_line();
        if (mix < 5)
          line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
      end
      send_line();
      if ($urandom_range(0, 15) == 0) wait_drained();
    end
  endtask

  task automatic test_backpressure();
    src_idle = 1'b0;
    sink_idle = 1'b0;
    sink_hold = 150;
    repeat (40) put_text("b,");
    put_byte(atl_pkg::CH_EOL);
    build_line();
    build_line();
    send_line();
    wait_drained();
    sink_idle = 1'b1;
    sink_hold = 60;
    repeat (4) build_line();
    send_line();
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    chars_bus.valid = 1'b0;
    chars_bus.char_code = '0;
    scan_mode = SCAN_IDLE;
    num_acc = '0;
    num_neg = 1'b0;
    reg_len = 0;
    for (int k = 0; k < 4; k++) reg_chars[k] = 8'h00;
    mismatch_count = 0;
    bytes_sent = 0;
    sink_gap = 0;
    sink_hold = 0;
    src_idle = 1'b1;
    sink_idle = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_lines();
    test_random_lines(1000);
    test_backpressure();
    test_random_lines(1550);
    wait_drained();
    repeat (16) @(posedge clk);
    if (token_queue.size() != 0)
      report_mismatch($sformatf("%0d tokens never arrived", token_queue.size()));
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/atl_pkg.sv
design/atl_char_if.sv
design/atl_tok_if.sv
design/assembly_token_lexer_core.sv
design/atl_checker.sv
bench/assembly_token_lexer_core_tb.sv
